@@ sv/sgmi_pkg.sv @@
// Shared types, codes and helper functions for the switchgear motor interlock.
`timescale 1ns / 1ps
`default_nettype none

package sgmi_pkg;

    // Debounce counter slots.
    localparam int NUM_CNT = 13;
    localparam int CNT_QSC = 0;
    localparam int CNT_QSO = 1;
    localparam int CNT_ESC = 2;
    localparam int CNT_ESO = 3;
    localparam int CNT_CMD = 4;
    localparam int CNT_RST = 5;
    localparam int CNT_FLT = 6;
    localparam int CNT_AQC = 7;
    localparam int CNT_AQO = 8;
    localparam int CNT_AEC = 9;
    localparam int CNT_AEO = 10;
    localparam int CNT_CHG = 11;
    localparam int CNT_CHD = 12;

    // Re-arm flag bits, one per switch command.
    localparam int ARM_QSC = 0;
    localparam int ARM_QSO = 1;
    localparam int ARM_ESC = 2;
    localparam int ARM_ESO = 3;

    // Legal command patterns {es_open, es_close, qs_open, qs_close}, active low.
    localparam logic [3:0] PAT_NONE   = 4'hF;
    localparam logic [3:0] PAT_QS_CLS = 4'hE;
    localparam logic [3:0] PAT_QS_OPN = 4'hD;
    localparam logic [3:0] PAT_ES_CLS = 4'hB;
    localparam logic [3:0] PAT_ES_OPN = 4'h7;

    // Configuration register indexes.
    localparam int CFG_IDX_BITS = 3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_START     = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ARRIVAL   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FAULT     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CHARGE    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RESET     = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CMD_ERROR = 3'd5;

    // Encoded run mode as seen on the result channel.
    localparam logic [2:0] RUN_IDLE     = 3'd0;
    localparam logic [2:0] RUN_QS_CLOSE = 3'd1;
    localparam logic [2:0] RUN_QS_OPEN  = 3'd2;
    localparam logic [2:0] RUN_ES_CLOSE = 3'd3;
    localparam logic [2:0] RUN_ES_OPEN  = 3'd4;
    localparam logic [2:0] RUN_CHARGE   = 3'd5;

    // Drive-off pulse bits.
    localparam int DRV_QSC = 0;
    localparam int DRV_QSO = 1;
    localparam int DRV_ESC = 2;
    localparam int DRV_ESO = 3;
    localparam int DRV_CHG = 4;

    typedef enum logic [5:0] {
        MODE_IDLE     = 6'b000001,
        MODE_QS_CLOSE = 6'b000010,
        MODE_QS_OPEN  = 6'b000100,
        MODE_ES_CLOSE = 6'b001000,
        MODE_ES_OPEN  = 6'b010000,
        MODE_CHARGE   = 6'b100000
    } mode_t;

    typedef struct packed {
        logic [3:0] start_lim;
        logic [3:0] arrival_lim;
        logic [3:0] fault_lim;
        logic [3:0] charge_done_lim;
        logic [3:0] reset_lim;
        logic [3:0] cmd_error_lim;
    } limits_t;

    typedef struct packed {
        logic qs_close_cmd_n;
        logic qs_open_cmd_n;
        logic es_close_cmd_n;
        logic es_open_cmd_n;
        logic qs_closed_pos_n;
        logic qs_opened_pos_n;
        logic es_closed_pos_n;
        logic es_opened_pos_n;
        logic lock_contact;
        logic charged_pos_n;
        logic reset_btn_n;
        logic external_alarm;
    } sample_t;

    // Control state other than the debounce counters.
    typedef struct packed {
        logic [3:0] rearm;
        mode_t      mode;
        logic       cmd_alarm;
        logic       run_alarm;
        logic       reset_req;
    } ctrl_t;

    typedef struct packed {
        logic [2:0] run_mode;
        logic       cmd_alarm;
        logic       run_alarm;
        logic       reset_request;
        logic       lock_relay_off;
        logic       alarm_relay_off;
        logic       stop_orders;
        logic [4:0] drive_off_mask;
        logic       clear_over1;
        logic       clear_over2;
    } result_t;

    // Maps the one-hot mode onto the external run mode code.
    function automatic logic [2:0] run_code(input mode_t mode);
        logic [2:0] code;
        unique case (mode)
            MODE_IDLE:     code = RUN_IDLE;
            MODE_QS_CLOSE: code = RUN_QS_CLOSE;
            MODE_QS_OPEN:  code = RUN_QS_OPEN;
            MODE_ES_CLOSE: code = RUN_ES_CLOSE;
            MODE_ES_OPEN:  code = RUN_ES_OPEN;
            MODE_CHARGE:   code = RUN_CHARGE;
            default:       code = RUN_IDLE;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

@@ sv/sgmi_rules.sv @@
// Per-tick rule evaluation: debounce counters, starts, supervision and arrivals.
`timescale 1ns / 1ps
`default_nettype none

module sgmi_rules #(
    parameter int COUNT_BITS = 4
) (
    input  wire sgmi_pkg::sample_t                          smp_i,
    input  wire sgmi_pkg::limits_t                          lim_i,
    input  wire sgmi_pkg::ctrl_t                            ctrl_i,
    input  wire [sgmi_pkg::NUM_CNT-1:0][COUNT_BITS-1:0]     cnt_i,
    output sgmi_pkg::ctrl_t                                 ctrl_o,
    output logic [sgmi_pkg::NUM_CNT-1:0][COUNT_BITS-1:0]    cnt_o,
    output sgmi_pkg::result_t                               res_o
);

    // Count one tick; the top bit flags that the limit was exceeded.
    function automatic logic [COUNT_BITS:0] tick_cnt(input logic [COUNT_BITS-1:0] cnt,
                                                     input logic [3:0] lim);
        logic [COUNT_BITS-1:0] inc;
        logic                  fire;
        inc  = cnt + COUNT_BITS'(1);
        fire = inc > COUNT_BITS'(lim);
        return {fire, fire ? {COUNT_BITS{1'b0}} : inc};
    endfunction

    // Start rule with re-arm: returns {fire, armed_next, count_next}.
    function automatic logic [COUNT_BITS+1:0] start_step(input logic cond,
                                                         input logic armed,
                                                         input logic cmd_n,
                                                         input logic [COUNT_BITS-1:0] cnt,
                                                         input logic [3:0] lim);
        logic [COUNT_BITS:0] t;
        logic [COUNT_BITS+1:0] r;
        t = tick_cnt(cnt, lim);
        if (cond) begin
            if (armed) begin
                r = {t[COUNT_BITS], ~t[COUNT_BITS], t[COUNT_BITS-1:0]};
            end else begin
                r = {1'b0, 1'b0, cnt};
            end
        end else begin
            r = {1'b0, armed | cmd_n, {COUNT_BITS{1'b0}}};
        end
        return r;
    endfunction

    logic [3:0]            pat;
    logic                  legal;
    logic                  both_pos;
    logic                  base_ok;
    logic                  ok;
    logic [COUNT_BITS:0]   t;
    logic [COUNT_BITS+1:0] st;
    sgmi_pkg::mode_t       mode;

    assign pat      = {smp_i.es_open_cmd_n, smp_i.es_close_cmd_n,
                       smp_i.qs_open_cmd_n, smp_i.qs_close_cmd_n};
    assign legal    = (pat == sgmi_pkg::PAT_NONE)   || (pat == sgmi_pkg::PAT_QS_CLS) ||
                      (pat == sgmi_pkg::PAT_QS_OPN) || (pat == sgmi_pkg::PAT_ES_CLS) ||
                      (pat == sgmi_pkg::PAT_ES_OPN);
    assign both_pos = !smp_i.qs_closed_pos_n && !smp_i.qs_opened_pos_n;

    // Rules run in a fixed order; each one sees what the earlier ones left.
    always_comb begin
        ctrl_o  = ctrl_i;
        cnt_o   = cnt_i;
        res_o   = '0;
        mode    = ctrl_i.mode;
        base_ok = 1'b0;
        ok      = 1'b0;
        t       = '0;
        st      = '0;

        // Illegal command or position pattern, checked only in idle.
        if (mode == sgmi_pkg::MODE_IDLE) begin
            if (!legal || both_pos) begin
                t = tick_cnt(cnt_o[sgmi_pkg::CNT_CMD], lim_i.cmd_error_lim);
                cnt_o[sgmi_pkg::CNT_CMD] = t[COUNT_BITS-1:0];
                if (t[COUNT_BITS]) begin
                    ctrl_o.cmd_alarm      = 1'b1;
                    res_o.alarm_relay_off = 1'b1;
                end
            end else begin
                cnt_o[sgmi_pkg::CNT_CMD] = '0;
                ctrl_o.cmd_alarm         = 1'b0;
            end
        end

        // Reset button.
        if (!smp_i.reset_btn_n) begin
            t = tick_cnt(cnt_o[sgmi_pkg::CNT_RST], lim_i.reset_lim);
            cnt_o[sgmi_pkg::CNT_RST] = t[COUNT_BITS-1:0];
            if (t[COUNT_BITS]) begin
                ctrl_o.reset_req = 1'b1;
            end
        end else begin
            cnt_o[sgmi_pkg::CNT_RST] = '0;
            ctrl_o.reset_req         = 1'b0;
        end

        // Load switch close.
        base_ok = !smp_i.qs_close_cmd_n && smp_i.qs_open_cmd_n && smp_i.es_close_cmd_n &&
                  smp_i.es_open_cmd_n && smp_i.qs_closed_pos_n && !smp_i.qs_opened_pos_n &&
                  smp_i.es_closed_pos_n && !smp_i.lock_contact && !smp_i.external_alarm &&
                  smp_i.reset_btn_n && !ctrl_o.cmd_alarm;
        ok = base_ok && !smp_i.charged_pos_n && (mode == sgmi_pkg::MODE_IDLE);
        st = start_step(ok, ctrl_o.rearm[sgmi_pkg::ARM_QSC], smp_i.qs_close_cmd_n,
                        cnt_o[sgmi_pkg::CNT_QSC], lim_i.start_lim);
        cnt_o[sgmi_pkg::CNT_QSC]            = st[COUNT_BITS-1:0];
        ctrl_o.rearm[sgmi_pkg::ARM_QSC]     = st[COUNT_BITS];
        if (st[COUNT_BITS+1]) begin
            mode = sgmi_pkg::MODE_QS_CLOSE;
        end

        // Spring charging start, no re-arm needed.
        ok = base_ok && smp_i.charged_pos_n && (mode == sgmi_pkg::MODE_IDLE);
        if (ok) begin
            t = tick_cnt(cnt_o[sgmi_pkg::CNT_CHG], lim_i.start_lim);
            cnt_o[sgmi_pkg::CNT_CHG] = t[COUNT_BITS-1:0];
            if (t[COUNT_BITS]) begin
                mode = sgmi_pkg::MODE_CHARGE;
            end
        end else begin
            cnt_o[sgmi_pkg::CNT_CHG] = '0;
        end

        // Load switch open.
        ok = !smp_i.qs_open_cmd_n && smp_i.qs_close_cmd_n && smp_i.es_close_cmd_n &&
             smp_i.es_open_cmd_n && smp_i.qs_opened_pos_n && smp_i.es_closed_pos_n &&
             !smp_i.lock_contact && (mode == sgmi_pkg::MODE_IDLE) &&
             !smp_i.external_alarm && smp_i.reset_btn_n && !ctrl_o.cmd_alarm;
        st = start_step(ok, ctrl_o.rearm[sgmi_pkg::ARM_QSO], smp_i.qs_open_cmd_n,
                        cnt_o[sgmi_pkg::CNT_QSO], lim_i.start_lim);
        cnt_o[sgmi_pkg::CNT_QSO]        = st[COUNT_BITS-1:0];
        ctrl_o.rearm[sgmi_pkg::ARM_QSO] = st[COUNT_BITS];
        if (st[COUNT_BITS+1]) begin
            mode = sgmi_pkg::MODE_QS_OPEN;
        end

        // Earth switch close.
        ok = !smp_i.es_close_cmd_n && smp_i.qs_close_cmd_n && smp_i.qs_open_cmd_n &&
             smp_i.es_open_cmd_n && smp_i.qs_closed_pos_n && smp_i.es_closed_pos_n &&
             !smp_i.es_opened_pos_n && !smp_i.lock_contact &&
             (mode == sgmi_pkg::MODE_IDLE) && !smp_i.external_alarm &&
             smp_i.reset_btn_n && !ctrl_o.cmd_alarm;
        st = start_step(ok, ctrl_o.rearm[sgmi_pkg::ARM_ESC], smp_i.es_close_cmd_n,
                        cnt_o[sgmi_pkg::CNT_ESC], lim_i.start_lim);
        cnt_o[sgmi_pkg::CNT_ESC]        = st[COUNT_BITS-1:0];
        ctrl_o.rearm[sgmi_pkg::ARM_ESC] = st[COUNT_BITS];
        if (st[COUNT_BITS+1]) begin
            mode = sgmi_pkg::MODE_ES_CLOSE;
        end

        // Earth switch open.
        ok = !smp_i.es_open_cmd_n && smp_i.qs_close_cmd_n && smp_i.qs_open_cmd_n &&
             smp_i.es_close_cmd_n && smp_i.qs_closed_pos_n && smp_i.es_opened_pos_n &&
             !smp_i.lock_contact && (mode == sgmi_pkg::MODE_IDLE) &&
             !smp_i.external_alarm && smp_i.reset_btn_n && !ctrl_o.cmd_alarm;
        st = start_step(ok, ctrl_o.rearm[sgmi_pkg::ARM_ESO], smp_i.es_open_cmd_n,
                        cnt_o[sgmi_pkg::CNT_ESO], lim_i.start_lim);
        cnt_o[sgmi_pkg::CNT_ESO]        = st[COUNT_BITS-1:0];
        ctrl_o.rearm[sgmi_pkg::ARM_ESO] = st[COUNT_BITS];
        if (st[COUNT_BITS+1]) begin
            mode = sgmi_pkg::MODE_ES_OPEN;
        end

        // Motion supervision: interlock abort, then end-position arrivals.
        if (mode != sgmi_pkg::MODE_IDLE) begin
            res_o.lock_relay_off = 1'b1;

            if (smp_i.lock_contact || both_pos) begin
                t = tick_cnt(cnt_o[sgmi_pkg::CNT_FLT], lim_i.fault_lim);
                cnt_o[sgmi_pkg::CNT_FLT] = t[COUNT_BITS-1:0];
                if (t[COUNT_BITS]) begin
                    mode              = sgmi_pkg::MODE_IDLE;
                    ctrl_o.run_alarm  = 1'b1;
                    res_o.stop_orders = 1'b1;
                end
            end else begin
                cnt_o[sgmi_pkg::CNT_FLT] = '0;
            end

            if (!smp_i.qs_closed_pos_n && (mode == sgmi_pkg::MODE_QS_CLOSE)) begin
                t = tick_cnt(cnt_o[sgmi_pkg::CNT_AQC], lim_i.arrival_lim);
                cnt_o[sgmi_pkg::CNT_AQC] = t[COUNT_BITS-1:0];
                if (t[COUNT_BITS]) begin
                    mode                                  = sgmi_pkg::MODE_IDLE;
                    res_o.drive_off_mask[sgmi_pkg::DRV_QSC] = 1'b1;
                    res_o.clear_over1                     = 1'b1;
                end
            end else begin
                cnt_o[sgmi_pkg::CNT_AQC] = '0;
            end

            if (!smp_i.qs_opened_pos_n && (mode == sgmi_pkg::MODE_QS_OPEN)) begin
                t = tick_cnt(cnt_o[sgmi_pkg::CNT_AQO], lim_i.arrival_lim);
                cnt_o[sgmi_pkg::CNT_AQO] = t[COUNT_BITS-1:0];
                if (t[COUNT_BITS]) begin
                    mode                                  = sgmi_pkg::MODE_IDLE;
                    res_o.drive_off_mask[sgmi_pkg::DRV_QSO] = 1'b1;
                    res_o.clear_over1                     = 1'b1;
                end
            end else begin
                cnt_o[sgmi_pkg::CNT_AQO] = '0;
            end

            if (!smp_i.es_closed_pos_n && (mode == sgmi_pkg::MODE_ES_CLOSE)) begin
                t = tick_cnt(cnt_o[sgmi_pkg::CNT_AEC], lim_i.arrival_lim);
                cnt_o[sgmi_pkg::CNT_AEC] = t[COUNT_BITS-1:0];
                if (t[COUNT_BITS]) begin
                    mode                                  = sgmi_pkg::MODE_IDLE;
                    res_o.drive_off_mask[sgmi_pkg::DRV_ESC] = 1'b1;
                    res_o.clear_over1                     = 1'b1;
                    res_o.clear_over2                     = 1'b1;
                end
            end else begin
                cnt_o[sgmi_pkg::CNT_AEC] = '0;
            end

            if (smp_i.es_closed_pos_n && !smp_i.es_opened_pos_n &&
                (mode == sgmi_pkg::MODE_ES_OPEN)) begin
                t = tick_cnt(cnt_o[sgmi_pkg::CNT_AEO], lim_i.arrival_lim);
                cnt_o[sgmi_pkg::CNT_AEO] = t[COUNT_BITS-1:0];
                if (t[COUNT_BITS]) begin
                    mode                                  = sgmi_pkg::MODE_IDLE;
                    res_o.drive_off_mask[sgmi_pkg::DRV_ESO] = 1'b1;
                    res_o.clear_over1                     = 1'b1;
                    res_o.clear_over2                     = 1'b1;
                end
            end else begin
                cnt_o[sgmi_pkg::CNT_AEO] = '0;
            end

            // Charge completion hands over to load switch closing.
            if (!smp_i.charged_pos_n && (mode == sgmi_pkg::MODE_CHARGE)) begin
                t = tick_cnt(cnt_o[sgmi_pkg::CNT_CHD], lim_i.charge_done_lim);
                cnt_o[sgmi_pkg::CNT_CHD] = t[COUNT_BITS-1:0];
                if (t[COUNT_BITS]) begin
                    mode                                  = sgmi_pkg::MODE_QS_CLOSE;
                    res_o.drive_off_mask[sgmi_pkg::DRV_CHG] = 1'b1;
                end
            end else begin
                cnt_o[sgmi_pkg::CNT_CHD] = '0;
            end
        end

        ctrl_o.mode         = mode;
        res_o.run_mode      = sgmi_pkg::run_code(mode);
        res_o.cmd_alarm     = ctrl_o.cmd_alarm;
        res_o.run_alarm     = ctrl_o.run_alarm;
        res_o.reset_request = ctrl_o.reset_req;
    end

endmodule

`default_nettype wire

@@ sv/switchgear_motor_interlock.sv @@
// Top level of the switchgear motor interlock: state, limits and result register.
//
// Usage: one input transfer on the s_ channel carries one sampled tick of the
// command, position, interlock, charge and reset contacts plus the external
// alarm level. Each accepted tick yields exactly one result transfer on the m_
// channel: the run mode after the tick, the alarm and reset levels, and the
// relay, stop, drive-off and overcurrent-clear pulses for that tick.
// The result is registered and is valid in the cycle after its tick is accepted.
// Throughput is one tick per cycle while the receiver does not stall; the rule
// chain between the state registers and the result register is combinational.
// When the receiver stalls, the result stays in the output register and
// s_ready drops only while that register is full and m_ready is low.
// The cfg_ channel writes the six 4-bit debounce limits by index; it is
// always ready and a write to an index beyond the list is ignored. Limits
// should only change while no tick is in flight.
// Reset (aresetn low, synchronous) clears all counters, re-arm flags and
// alarms, returns the mode to idle, loads the default limits and empties
// the output register.
`timescale 1ns / 1ps
`default_nettype none

module switchgear_motor_interlock #(
    parameter int COUNT_BITS = 4
) (
    input  wire         aclk,
    input  wire         aresetn,

    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire [2:0]   cfg_index,
    input  wire [3:0]   cfg_data,

    input  wire         s_valid,
    output logic        s_ready,
    input  wire         s_qs_close_cmd_n,
    input  wire         s_qs_open_cmd_n,
    input  wire         s_es_close_cmd_n,
    input  wire         s_es_open_cmd_n,
    input  wire         s_qs_closed_pos_n,
    input  wire         s_qs_opened_pos_n,
    input  wire         s_es_closed_pos_n,
    input  wire         s_es_opened_pos_n,
    input  wire         s_lock_contact,
    input  wire         s_charged_pos_n,
    input  wire         s_reset_btn_n,
    input  wire         s_external_alarm,

    output logic        m_valid,
    input  wire         m_ready,
    output logic [2:0]  m_run_mode,
    output logic        m_cmd_alarm,
    output logic        m_run_alarm,
    output logic        m_reset_request,
    output logic        m_lock_relay_off,
    output logic        m_alarm_relay_off,
    output logic        m_stop_orders,
    output logic [4:0]  m_drive_off_mask,
    output logic        m_clear_over1,
    output logic        m_clear_over2
);

    sgmi_pkg::limits_t                              lim_reg;
    sgmi_pkg::ctrl_t                                ctrl_reg;
    sgmi_pkg::ctrl_t                                ctrl_next;
    logic [sgmi_pkg::NUM_CNT-1:0][COUNT_BITS-1:0]   cnt_reg;
    logic [sgmi_pkg::NUM_CNT-1:0][COUNT_BITS-1:0]   cnt_next;
    sgmi_pkg::result_t                              res_reg;
    sgmi_pkg::result_t                              res_next;
    sgmi_pkg::sample_t                              smp;
    logic                                           m_valid_reg;
    logic                                           s_xfer;

    // Gather the sampled contacts into one word.
    assign smp = '{
        qs_close_cmd_n:  s_qs_close_cmd_n,
        qs_open_cmd_n:   s_qs_open_cmd_n,
        es_close_cmd_n:  s_es_close_cmd_n,
        es_open_cmd_n:   s_es_open_cmd_n,
        qs_closed_pos_n: s_qs_closed_pos_n,
        qs_opened_pos_n: s_qs_opened_pos_n,
        es_closed_pos_n: s_es_closed_pos_n,
        es_opened_pos_n: s_es_opened_pos_n,
        lock_contact:    s_lock_contact,
        charged_pos_n:   s_charged_pos_n,
        reset_btn_n:     s_reset_btn_n,
        external_alarm:  s_external_alarm
    };

    // Handshake: take a tick whenever the output register is free or draining.
    assign s_ready   = !m_valid_reg || m_ready;
    assign s_xfer    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    sgmi_rules #(
        .COUNT_BITS (COUNT_BITS)
    ) u_rules (
        .smp_i  (smp),
        .lim_i  (lim_reg),
        .ctrl_i (ctrl_reg),
        .cnt_i  (cnt_reg),
        .ctrl_o (ctrl_next),
        .cnt_o  (cnt_next),
        .res_o  (res_next)
    );

    // Limit registers written through the configuration channel.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lim_reg.start_lim       <= 4'd10;
            lim_reg.arrival_lim     <= 4'd5;
            lim_reg.fault_lim       <= 4'd5;
            lim_reg.charge_done_lim <= 4'd10;
            lim_reg.reset_lim       <= 4'd10;
            lim_reg.cmd_error_lim   <= 4'd5;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                sgmi_pkg::CFG_START:     lim_reg.start_lim       <= cfg_data;
                sgmi_pkg::CFG_ARRIVAL:   lim_reg.arrival_lim     <= cfg_data;
                sgmi_pkg::CFG_FAULT:     lim_reg.fault_lim       <= cfg_data;
                sgmi_pkg::CFG_CHARGE:    lim_reg.charge_done_lim <= cfg_data;
                sgmi_pkg::CFG_RESET:     lim_reg.reset_lim       <= cfg_data;
                sgmi_pkg::CFG_CMD_ERROR: lim_reg.cmd_error_lim   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Interlock state advances once per accepted tick.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg.rearm     <= '0;
            ctrl_reg.mode      <= sgmi_pkg::MODE_IDLE;
            ctrl_reg.cmd_alarm <= 1'b0;
            ctrl_reg.run_alarm <= 1'b0;
            ctrl_reg.reset_req <= 1'b0;
            cnt_reg            <= '0;
        end else if (s_xfer) begin
            ctrl_reg <= ctrl_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Output register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_xfer) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            res_reg <= res_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_run_mode        = res_reg.run_mode;
    assign m_cmd_alarm       = res_reg.cmd_alarm;
    assign m_run_alarm       = res_reg.run_alarm;
    assign m_reset_request   = res_reg.reset_request;
    assign m_lock_relay_off  = res_reg.lock_relay_off;
    assign m_alarm_relay_off = res_reg.alarm_relay_off;
    assign m_stop_orders     = res_reg.stop_orders;
    assign m_drive_off_mask  = res_reg.drive_off_mask;
    assign m_clear_over1     = res_reg.clear_over1;
    assign m_clear_over2     = res_reg.clear_over2;

`ifndef ASSERT_OFF
    // The run alarm is sticky once set.
    a_run_alarm_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_reg.run_alarm |=> ctrl_reg.run_alarm)
        else $error("run alarm cleared after being set");

    // Interlock state only moves on an accepted tick.
    a_state_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_xfer |=> $stable(ctrl_reg) && $stable(cnt_reg))
        else $error("interlock state changed without an input transfer");

    // A fault abort leaves the block idle with the run alarm raised.
    a_stop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_stop_orders) |->
            (m_run_mode == sgmi_pkg::RUN_IDLE) && m_run_alarm)
        else $error("stop pulse without idle mode and run alarm");

    // Charge completion always hands over to load switch closing.
    a_charge_to_close: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_drive_off_mask[sgmi_pkg::DRV_CHG]) |->
            (m_run_mode == sgmi_pkg::RUN_QS_CLOSE))
        else $error("charge drive off without load switch closing");

    // The alarm relay pulse only comes with the command alarm level.
    a_relay_with_alarm: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_alarm_relay_off) |-> m_cmd_alarm)
        else $error("alarm relay pulse without command alarm");
`endif

endmodule

`default_nettype wire
